@@ hw/rtl/icc_pkg.sv @@
// ----------------------------------------------------------------------------
// icc_pkg
// Shared sizes, register indexes and control types for the crop window
// with claim map.
// ----------------------------------------------------------------------------
package icc_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int COORD_W = 16;
    localparam int PIXEL_W = 32;
    localparam int DIM_W   = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [PIXEL_W-1:0] RGB_MASK = 32'h00FF_FFFF;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH      = 8'd0,
        REG_IMAGE_HEIGHT     = 8'd1,
        REG_HAS_ALPHA        = 8'd2,
        REG_CHECK_DUPLICATES = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic clear;
        logic capture;
        logic access;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_busy;
    } t_sts;

endpackage

@@ hw/rtl/icc_ctrl.sv @@
// ----------------------------------------------------------------------------
// icc_ctrl
// Sequencer: claim map clear after reset, then capture, memory access and
// result hand-off for each item.
// ----------------------------------------------------------------------------
module icc_ctrl
    import icc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_FINISH
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_done) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_ACCESS;
                end
                S_ACCESS: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!i_sts.out_busy) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.clear   = (r_state == S_CLEAR);
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.access  = (r_state == S_ACCESS);
        o_cmd.finish  = (r_state == S_FINISH) && !i_sts.out_busy;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hw/rtl/icc_datapath.sv @@
// ----------------------------------------------------------------------------
// icc_datapath
// Configuration registers, bounds check, pixel store, claim map and the
// output register.
// ----------------------------------------------------------------------------
module icc_datapath
    import icc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_action,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic [PIXEL_W-1:0]    i_pixel_in,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIXEL_W-1:0]    o_pixel_out,
    output logic                  o_inside_res,
    output logic                  o_already_claimed
);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             r_has_alpha;
    logic             r_check_dup;

    logic                      r_action;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [PIXEL_W-1:0]        r_pix;
    logic                      r_inside;
    logic [ADDR_W-1:0]         r_addr;
    logic [ADDR_W-1:0]         r_clr_cnt;

    logic [PIXEL_W-1:0] r_store [STORE_DEPTH];
    logic               r_claim [STORE_DEPTH];
    logic [PIXEL_W-1:0] r_store_q;
    logic               r_claim_q;

    logic                r_out_valid;
    logic [PIXEL_W-1:0]  r_pixel_out;
    logic                r_inside_out;
    logic                r_claimed_out;

    logic [COORD_W-1:0] eff_w;
    logic [COORD_W-1:0] eff_h;
    logic               in_bounds;
    logic [ADDR_W-1:0]  addr;
    logic               fetch_ok;
    logic               claimed;
    logic               claim_set;
    logic [PIXEL_W-1:0] n_pixel;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= '0;
            r_height    <= '0;
            r_has_alpha <= 1'b1;
            r_check_dup <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:      r_width     <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:     r_height    <= i_cfg_data[DIM_W-1:0];
                REG_HAS_ALPHA:        r_has_alpha <= i_cfg_data[0];
                REG_CHECK_DUPLICATES: r_check_dup <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // bounds and address
    always_comb begin
        eff_w  = (32'(r_width) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : COORD_W'(r_width);
        eff_h  = (32'(r_height) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : COORD_W'(r_height);
        in_bounds = !r_x[COORD_W-1] && !r_y[COORD_W-1]
                 && ($unsigned(r_x) < eff_w) && ($unsigned(r_y) < eff_h);
        addr   = ADDR_W'(32'($unsigned(r_y)) * MAX_WIDTH + 32'($unsigned(r_x)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_pix    <= i_pixel_in;
        end
        if (i_cmd.access) begin
            r_inside <= in_bounds;
            r_addr   <= addr;
        end
    end

    // pixel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.access && in_bounds && (r_action == ACT_WRITE)) begin
            r_store[addr] <= r_pix;
        end
        if (i_cmd.access && in_bounds && (r_action == ACT_FETCH)) begin
            r_store_q <= r_store[addr];
        end
    end

    // result
    always_comb begin
        fetch_ok  = r_inside && (r_action == ACT_FETCH);
        claimed   = fetch_ok && r_check_dup && r_claim_q;
        claim_set = fetch_ok && r_check_dup && !r_claim_q;
        if (fetch_ok && !claimed) begin
            n_pixel = r_has_alpha ? r_store_q : (r_store_q & RGB_MASK);
        end else begin
            n_pixel = '0;
        end
    end

    // claim map, swept clear after reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_claim[r_clr_cnt] <= 1'b0;
        end else if (i_cmd.finish && claim_set) begin
            r_claim[r_addr] <= 1'b1;
        end
        if (i_cmd.access && in_bounds && (r_action == ACT_FETCH)) begin
            r_claim_q <= r_claim[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_pixel_out   <= n_pixel;
            r_inside_out  <= r_inside;
            r_claimed_out <= claimed;
        end
    end

    assign o_sts.clear_done = (r_clr_cnt == ADDR_W'(STORE_DEPTH - 1));
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_pixel_out       = r_pixel_out;
    assign o_inside_res      = r_inside_out;
    assign o_already_claimed = r_claimed_out;

endmodule

@@ hw/rtl/image_crop_with_claim_map.sv @@
// ----------------------------------------------------------------------------
// image_crop_with_claim_map
// Crop window pixel source: pixel store loaded by write items, signed
// fetches with bounds check and an optional once-only claim map.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready  | action, pos_x, pos_y, pixel_in
//   out     | output    | o_out_valid / i_out_ready| pixel_out, inside_res,
//           |           |                          | already_claimed
//   cfg     | input     | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
// Each item goes through capture, memory access and result load in turn; the
// single port of the pixel store and claim map keeps these steps apart.
// After reset the claim map is swept clear, one entry a cycle, over all 65536
// entries; no item is taken meanwhile, config writes are.
// A stalled output holds the last result; the next item is taken and waits
// in its final step until the output register frees up.
// ----------------------------------------------------------------------------
module image_crop_with_claim_map
    import icc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic [PIXEL_W-1:0]        i_pixel_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [PIXEL_W-1:0]        o_pixel_out,
    output logic                      o_inside_res,
    output logic                      o_already_claimed,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    icc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    icc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pixel_in        (i_pixel_in),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pixel_out       (o_pixel_out),
        .o_inside_res      (o_inside_res),
        .o_already_claimed (o_already_claimed)
    );

endmodule

@@ hw/rtl/icc_checker.sv @@
// ----------------------------------------------------------------------------
// icc_checker
// Port-level checks on the crop window results, bound to the top level.
// ----------------------------------------------------------------------------
module icc_checker
    import icc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [PIXEL_W-1:0] o_pixel_out,
    input logic               o_inside_res,
    input logic               o_already_claimed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_out))
        else $error("output item changed while stalled");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_res |-> o_pixel_out == '0 && !o_already_claimed)
        else $error("outside point gave nonzero result");

    a_claimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_already_claimed |-> o_pixel_out == '0 && o_inside_res)
        else $error("claimed pixel not zero or not inside");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind image_crop_with_claim_map icc_checker u_icc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_pixel_out       (o_pixel_out),
    .o_inside_res      (o_inside_res),
    .o_already_claimed (o_already_claimed)
);
